// ===== hdl/xbm_pkg.sv =====
// Shared types, codes and character helpers for the XBM body decoder.
`default_nettype none
package xbm_pkg;

    localparam int unsigned XBM_MAX_DIM = 4096;
    localparam int unsigned CFG_DATA_W  = 13;

    localparam logic [31:0] PIX_BLACK = 32'hFF000000;
    localparam logic [31:0] PIX_WHITE = 32'hFFFFFFFF;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IDX_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_IDX_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_IDX_MODE   = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_stream;
    } t_item;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        last_of_run;
        logic        image_complete;
        logic        load_error;
    } t_result;

    // One finished word (or the early-end marker) handed to the pixel expander.
    typedef struct packed {
        logic        is_err;
        logic        last_word;
        logic [15:0] word;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic has_pad;
        logic busy;
        logic load;
    } t_cfg_ctrl;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c inside {CH_SPACE, CH_COMMA, CH_RBRACE, CH_LF, CH_TAB};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/xbm_hex_to_pixel_decoder.sv =====
// Top level of the XBM body decoder: classifier, word queue, expander, result queue.
// Accepts one body character per cycle while the four-entry word queue has room.
// Digits and ignored characters produce nothing; a delimiter that closes a word
// yields min(8, bits left in the row) pixels per byte, one or two bytes per word,
// so up to 16 results, which the pixel expander delivers one per cycle into a
// two-entry result queue while that queue has room. Sustained rate is therefore
// set by the expander. After reset and after each write to width, height or mode,
// full stays high while the row length times the height is multiplied out into
// the word total. End of stream before the last word gives a single error result;
// once the image is done or has failed, further input is taken and dropped.
`default_nettype none
module xbm_hex_to_pixel_decoder #(
    parameter int unsigned MAX_DIMENSION = xbm_pkg::XBM_MAX_DIM
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    input  wire xbm_pkg::t_item                 i_item,
    output logic                                full,
    output logic                                empty,
    input  wire logic                           pop,
    output xbm_pkg::t_result                    o_result,
    input  wire logic                           i_cfg_we,
    input  wire xbm_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [xbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import xbm_pkg::*;

    localparam int unsigned DIM_W   = $clog2(MAX_DIMENSION + 1);
    localparam int unsigned BPR_MAX = (MAX_DIMENSION + 7) / 8 + 1;
    localparam int unsigned BPR_W   = $clog2(BPR_MAX + 1);
    localparam int unsigned TOT_W   = BPR_W + DIM_W;
    localparam int unsigned CMD_W   = $bits(t_cmd);
    localparam int unsigned RES_W   = $bits(t_result);
    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned RES_DEPTH = 2;

    logic [DIM_W-1:0] width;
    logic [BPR_W-1:0] bpr;
    logic [TOT_W-1:0] total;
    t_cfg_ctrl        ctrl;

    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd             cmd_in;
    logic [CMD_W-1:0] cmd_q;
    logic             res_push, res_full;
    t_result          res_in;
    logic [RES_W-1:0] res_q;

    xbm_cfg #(
        .MAX_DIMENSION(MAX_DIMENSION),
        .DIM_W(DIM_W),
        .BPR_W(BPR_W),
        .TOT_W(TOT_W)
    ) u_cfg (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_width(width),
        .o_bpr(bpr),
        .o_total(total),
        .o_ctrl(ctrl)
    );

    xbm_front #(
        .TOT_W(TOT_W)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .i_item(i_item),
        .full(full),
        .i_ctrl(ctrl),
        .i_total(total),
        .i_cmd_full(cmd_full),
        .o_cmd_push(cmd_push),
        .o_cmd(cmd_in)
    );

    xbm_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(cmd_push),
        .i_data(cmd_in),
        .o_full(cmd_full),
        .i_pop(cmd_pop),
        .o_data(cmd_q),
        .o_empty(cmd_empty)
    );

    xbm_back #(
        .DIM_W(DIM_W),
        .BPR_W(BPR_W)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl(ctrl),
        .i_width(width),
        .i_bpr(bpr),
        .i_cmd_valid(~cmd_empty),
        .i_cmd(t_cmd'(cmd_q)),
        .o_cmd_pop(cmd_pop),
        .i_res_full(res_full),
        .o_res_push(res_push),
        .o_res(res_in)
    );

    xbm_fifo #(
        .WIDTH(RES_W),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(res_push),
        .i_data(res_in),
        .o_full(res_full),
        .i_pop(pop),
        .o_data(res_q),
        .o_empty(empty)
    );

    assign o_result = t_result'(res_q);
endmodule
`default_nettype wire

// ===== hdl/xbm_fifo.sv =====
// Small register-based FIFO used for the word queue and the result queue.
`default_nettype none
module xbm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= ptr_inc(r_wr);
            if (do_pop)  r_rd <= ptr_inc(r_rd);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/xbm_cfg.sv =====
// Configuration registers, row geometry and the per-image word total.
`default_nettype none
module xbm_cfg #(
    parameter int unsigned MAX_DIMENSION = 4096,
    parameter int unsigned DIM_W         = 13,
    parameter int unsigned BPR_W         = 10,
    parameter int unsigned TOT_W         = 23
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire xbm_pkg::t_cfg_idx               i_cfg_idx,
    input  wire logic [xbm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [DIM_W-1:0]                     o_width,
    output logic [BPR_W-1:0]                     o_bpr,
    output logic [TOT_W-1:0]                     o_total,
    output xbm_pkg::t_cfg_ctrl                   o_ctrl
);
    import xbm_pkg::*;

    localparam logic [1:0] SETUP_CYCLES = 2'd2;

    logic [DIM_W-1:0] r_width, r_height;
    logic             r_mode;
    logic [1:0]       r_setup;
    logic [TOT_W-1:0] r_prod;
    logic             has_pad;
    logic [DIM_W:0]   width_rnd;
    logic [TOT_W:0]   prod_inc;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIMENSION)) begin
            r = DIM_W'(MAX_DIMENSION);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // Padding byte per row when the width leaves 1..8 bits in the last word.
    assign has_pad   = r_mode && (r_width[3:0] != 4'd0) && (r_width[3:0] < 4'd9);
    assign width_rnd = {1'b0, r_width} + (DIM_W + 1)'(7);
    assign o_bpr     = BPR_W'(width_rnd >> 3) + BPR_W'(has_pad);
    assign o_width   = r_width;
    assign prod_inc  = {1'b0, r_prod} + (TOT_W + 1)'(1);
    assign o_total   = r_mode ? prod_inc[TOT_W:1] : r_prod;

    assign o_ctrl.mode    = r_mode;
    assign o_ctrl.has_pad = has_pad;
    assign o_ctrl.busy    = (r_setup != 2'd0);
    assign o_ctrl.load    = (r_setup == 2'd1);

    always_ff @(posedge i_clk) begin
        r_prod <= TOT_W'(o_bpr) * TOT_W'(r_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_mode   <= 1'b0;
            r_setup  <= SETUP_CYCLES;
        end else begin
            r_setup <= (r_setup != 2'd0) ? r_setup - 2'd1 : 2'd0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_WIDTH: begin
                        r_width <= clamp_dim(i_cfg_data);
                        r_setup <= SETUP_CYCLES;
                    end
                    CFG_IDX_HEIGHT: begin
                        r_height <= clamp_dim(i_cfg_data);
                        r_setup  <= SETUP_CYCLES;
                    end
                    CFG_IDX_MODE: begin
                        r_mode  <= i_cfg_data[0];
                        r_setup <= SETUP_CYCLES;
                    end
                    default: begin
                        r_setup <= (r_setup != 2'd0) ? r_setup - 2'd1 : 2'd0;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/xbm_front.sv =====
// Character classifier: gathers hex digits and queues each finished word or the early-end marker.
`default_nettype none
module xbm_front #(
    parameter int unsigned TOT_W = 23
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    input  wire xbm_pkg::t_item     i_item,
    output logic                    full,
    input  wire xbm_pkg::t_cfg_ctrl i_ctrl,
    input  wire logic [TOT_W-1:0]   i_total,
    input  wire logic               i_cmd_full,
    output logic                    o_cmd_push,
    output xbm_pkg::t_cmd           o_cmd
);
    import xbm_pkg::*;

    logic [15:0]      r_acc;
    logic             r_seen;
    logic             r_finished;
    logic [TOT_W-1:0] r_words;
    logic [4:0]       hex;
    logic             live, is_eos, is_dig, is_end;

    assign full   = i_cmd_full | i_ctrl.busy;
    assign hex    = hex_digit(i_item.char_code);
    assign live   = push & ~full & ~r_finished;
    assign is_eos = live & i_item.end_of_stream;
    assign is_dig = live & ~i_item.end_of_stream & hex[4];
    assign is_end = live & ~i_item.end_of_stream & ~hex[4] &
                    is_delim(i_item.char_code) & r_seen;

    assign o_cmd_push      = is_eos | is_end;
    assign o_cmd.is_err    = is_eos;
    assign o_cmd.last_word = (r_words == TOT_W'(1));
    assign o_cmd.word      = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_seen     <= 1'b0;
            r_finished <= 1'b0;
            r_words    <= '0;
        end else if (i_ctrl.load) begin
            r_acc      <= '0;
            r_seen     <= 1'b0;
            r_finished <= 1'b0;
            r_words    <= i_total;
        end else begin
            if (is_dig) begin
                r_acc  <= {r_acc[11:0], hex[3:0]};
                r_seen <= 1'b1;
            end
            if (is_end) begin
                r_acc  <= '0;
                r_seen <= 1'b0;
                if (r_words != '0) r_words <= r_words - TOT_W'(1);
                if (r_words == TOT_W'(1)) r_finished <= 1'b1;
            end
            if (is_eos) r_finished <= 1'b1;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_cmd_full)
        else $error("word queue written while full");

    a_finished_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished && !i_ctrl.load) |=> r_finished)
        else $error("finished flag dropped without restart");
endmodule
`default_nettype wire

// ===== hdl/xbm_back.sv =====
// Pixel expander: walks each queued word bit by bit with row trimming.
`default_nettype none
module xbm_back #(
    parameter int unsigned DIM_W = 13,
    parameter int unsigned BPR_W = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire xbm_pkg::t_cfg_ctrl i_ctrl,
    input  wire logic [DIM_W-1:0]   i_width,
    input  wire logic [BPR_W-1:0]   i_bpr,
    input  wire logic               i_cmd_valid,
    input  wire xbm_pkg::t_cmd      i_cmd,
    output logic                    o_cmd_pop,
    input  wire logic               i_res_full,
    output logic                    o_res_push,
    output xbm_pkg::t_result        o_res
);
    import xbm_pkg::*;

    logic [DIM_W-1:0] r_rbl;
    logic [BPR_W-1:0] r_pos;
    logic [2:0]       r_bit;
    logic             r_hi;

    logic [3:0]       n;
    logic             bit_last, skip_hi, final_byte, go, word_done;
    logic [7:0]       cur_byte;
    logic [BPR_W:0]   pos_inc1, pos_inc2, pos_wrap1, pos_wrap2;
    logic [DIM_W-1:0] rbl_rem;

    always_comb begin
        n          = (r_rbl < DIM_W'(8)) ? 4'(r_rbl) : 4'd8;
        bit_last   = (({1'b0, r_bit} + 4'd1) == n);
        cur_byte   = r_hi ? i_cmd.word[15:8] : i_cmd.word[7:0];
        pos_inc1   = {1'b0, r_pos} + (BPR_W + 1)'(1);
        pos_wrap1  = (pos_inc1 == {1'b0, i_bpr}) ? '0 : pos_inc1;
        pos_inc2   = {1'b0, r_pos} + (BPR_W + 1)'(2);
        pos_wrap2  = (pos_inc2 >= {1'b0, i_bpr}) ? pos_inc2 - {1'b0, i_bpr} : pos_inc2;
        // Drop the padding high byte of a row's last word.
        skip_hi    = i_ctrl.has_pad && (pos_wrap2 == '0);
        final_byte = ~i_ctrl.mode | r_hi | skip_hi;
        rbl_rem    = r_rbl - DIM_W'(n);
        go         = i_cmd_valid & ~i_res_full;
        word_done  = bit_last & final_byte;

        o_res_push = go;
        o_cmd_pop  = go & (i_cmd.is_err | word_done);
        if (i_cmd.is_err) begin
            o_res.pixel_color    = '0;
            o_res.last_of_run    = 1'b0;
            o_res.image_complete = 1'b0;
            o_res.load_error     = 1'b1;
        end else begin
            o_res.pixel_color    = cur_byte[r_bit] ? PIX_BLACK : PIX_WHITE;
            o_res.last_of_run    = word_done;
            o_res.image_complete = word_done & i_cmd.last_word;
            o_res.load_error     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbl <= DIM_W'(1);
            r_pos <= '0;
            r_bit <= '0;
            r_hi  <= 1'b0;
        end else if (i_ctrl.load) begin
            r_rbl <= i_width;
            r_pos <= '0;
            r_bit <= '0;
            r_hi  <= 1'b0;
        end else if (go && !i_cmd.is_err) begin
            if (bit_last) begin
                r_bit <= '0;
                r_rbl <= (rbl_rem == '0) ? i_width : rbl_rem;
                if (final_byte) begin
                    r_hi  <= 1'b0;
                    r_pos <= i_ctrl.mode ? BPR_W'(pos_wrap2) : BPR_W'(pos_wrap1);
                end else begin
                    r_hi <= 1'b1;
                end
            end else begin
                r_bit <= r_bit + 3'd1;
            end
        end
    end

    a_no_res_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result queue written while full");

    a_bit_in_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && !i_cmd.is_err) |-> ({1'b0, r_bit} < n))
        else $error("bit index past the trimmed byte");

    a_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rbl != '0)
        else $error("row bit count reached zero");
endmodule
`default_nettype wire

// ===== tb/xbm_hex_to_pixel_decoder_test.sv =====
// Self-checking testbench for the XBM body decoder: directed table, then random bitmap bodies.
`default_nettype none
module xbm_hex_to_pixel_decoder_test;
    import xbm_pkg::*;

    localparam int unsigned MAX_DIM     = XBM_MAX_DIM;
    localparam int          SETTLE      = 40;    // covers words still in flight with no pixels
    localparam int          HOLD_CYCLES = 400;   // long receiver hold-off in the pressure phase
    // Slowest legal quiet stretch is the hold-off plus a settle; allow several times that.
    localparam int          QUIET_LIMIT = 3000;
    localparam int          CHAR_TARGET = 360;

    typedef enum logic {ROW_CHAR, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [12:0] data;
        t_item       item;
        logic        typed;
        t_result     want;
    } t_row;

    localparam t_item   NO_CHAR = '0;
    localparam t_item   EOS     = '{8'hA5, 1'b1};
    localparam t_result NO_RES  = '0;
    localparam t_result ERR_RES = '{32'h0, 1'b0, 1'b0, 1'b1};
    localparam t_result ONE_PIX = '{PIX_BLACK, 1'b1, 1'b1, 1'b0};

    // Directed walk; starts from the reset setting of a 1x1 byte-mode image.
    localparam t_row DIRECTED [29] = '{
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h00, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{CH_COMMA, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'hFF, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h31, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{CH_LF, 1'b0}, 1'b1, ONE_PIX},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     EOS, 1'b0, NO_RES},
        '{ROW_REG,  CFG_IDX_WIDTH,  13'd0,     NO_CHAR, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     EOS, 1'b1, ERR_RES},
        '{ROW_REG,  CFG_IDX_WIDTH,  13'h1FFF,  NO_CHAR, 1'b0, NO_RES},
        '{ROW_REG,  CFG_IDX_HEIGHT, 13'h1FFF,  NO_CHAR, 1'b0, NO_RES},
        '{ROW_REG,  CFG_IDX_MODE,   13'h1FFF,  NO_CHAR, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h66, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h41, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h39, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h30, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h65, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{CH_TAB, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h46, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{CH_RBRACE, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     EOS, 1'b1, ERR_RES},
        '{ROW_REG,  CFG_IDX_WIDTH,  13'd3,     NO_CHAR, 1'b0, NO_RES},
        '{ROW_REG,  CFG_IDX_HEIGHT, 13'd1,     NO_CHAR, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h61, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h37, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{CH_SPACE, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h30, 1'b0}, 1'b0, NO_RES},
        '{ROW_REG,  CFG_IDX_MODE,   13'd0,     NO_CHAR, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{8'h64, 1'b0}, 1'b0, NO_RES},
        '{ROW_CHAR, CFG_IDX_WIDTH,  13'd0,     '{CH_COMMA, 1'b0}, 1'b0, NO_RES}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    t_item                 i_item     = '0;
    logic                  pop        = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = CFG_IDX_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  full;
    logic                  empty;
    t_result               o_result;

    // Decoder shadow: configuration and body state.
    logic [12:0] reg_width;
    logic [12:0] reg_height;
    logic        reg_short;
    logic [15:0] acc;
    logic        have_digit;
    logic [12:0] row_left;
    logic [9:0]  row_pos;
    logic [23:0] words_left;
    logic        image_done;

    t_result fresh_run [$];
    t_result pixels_due [$];
    t_result want;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          long_hold      = 1'b0;
    int          hold_count     = 0;
    int          quiet_cycles   = 0;
    int          mismatches     = 0;
    int          pixels_seen    = 0;
    int          errors_seen    = 0;
    int          chars_fed      = 0;
    int          settings_run   = 0;

    xbm_hex_to_pixel_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned dim_eff(input logic [12:0] v);
        if (v == 13'd0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic bit pad_on();
        int unsigned r;
        r = dim_eff(reg_width) % 16;
        return reg_short && r != 0 && r < 9;
    endfunction

    function automatic int unsigned row_bytes();
        return (dim_eff(reg_width) + 7) / 8 + (pad_on() ? 1 : 0);
    endfunction

    task automatic restart_decode();
        int unsigned total;
        total = row_bytes() * dim_eff(reg_height);
        acc        = '0;
        have_digit = 1'b0;
        row_left   = 13'(dim_eff(reg_width));
        row_pos    = '0;
        words_left = 24'(reg_short ? (total + 1) / 2 : total);
        image_done = 1'b0;
    endtask

    task automatic load_reg(input t_cfg_idx idx, input logic [12:0] data);
        case (idx)
            CFG_IDX_WIDTH:  reg_width  = data;
            CFG_IDX_HEIGHT: reg_height = data;
            CFG_IDX_MODE:   reg_short  = data[0];
            default:        return;
        endcase
        restart_decode();
    endtask

    // Expand one byte LSB first, cut to what is left of the current row.
    task automatic expand_byte(input logic [7:0] b);
        int unsigned n;
        t_result     r;
        n = (row_left < 8) ? row_left : 8;
        for (int unsigned i = 0; i < n; i++) begin
            r = '0;
            r.pixel_color = b[i] ? PIX_BLACK : PIX_WHITE;
            fresh_run.push_back(r);
        end
        row_left = row_left - 13'(n);
        if (row_left == 13'd0) row_left = 13'(dim_eff(reg_width));
    endtask

    task automatic decode_char(input t_item it);
        logic [7:0]  c;
        logic [3:0]  nib;
        bit          is_hex;
        logic [15:0] word;
        int unsigned bpr;
        int unsigned nxt;
        int          last;
        fresh_run.delete();
        if (image_done) return;
        if (it.end_of_stream) begin
            fresh_run.push_back(ERR_RES);
            image_done = 1'b1;
            return;
        end
        c = it.char_code;
        is_hex = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) nib = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) nib = c[3:0] + 4'd9;
        else is_hex = 1'b0;
        if (is_hex) begin
            acc = {acc[11:0], nib};
            have_digit = 1'b1;
            return;
        end
        if (!(c == CH_SPACE || c == CH_COMMA || c == CH_RBRACE || c == CH_LF || c == CH_TAB)
            || !have_digit) return;
        word = acc;
        acc = '0;
        have_digit = 1'b0;
        bpr = row_bytes();
        expand_byte(word[7:0]);
        if (reg_short) begin
            nxt = row_pos + 2;
            // Drop the padding high byte at the end of a row.
            if (!pad_on() || (nxt % bpr) != 0) expand_byte(word[15:8]);
            row_pos = 10'(nxt % bpr);
        end else begin
            row_pos = 10'((row_pos + 1) % bpr);
        end
        if (words_left != 0) words_left = words_left - 24'd1;
        last = fresh_run.size() - 1;
        fresh_run[last].last_of_run = 1'b1;
        if (words_left == 0) begin
            fresh_run[last].image_complete = 1'b1;
            image_done = 1'b1;
        end
    endtask

    // Present one request, wait for it to be taken, then book its pixels.
    task automatic offer(input t_item it, input logic typed, input t_result typed_res);
        int unsigned gap;
        bit          live;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        live = !image_done;
        decode_char(it);
        if (live) chars_fed++;
        if (typed) pixels_due.push_back(typed_res);
        else foreach (fresh_run[i]) pixels_due.push_back(fresh_run[i]);
    endtask

    task automatic feed_char(input logic [7:0] ch, input logic eos);
        t_item it;
        it.char_code     = ch;
        it.end_of_stream = eos;
        offer(it, 1'b0, NO_RES);
    endtask

    // Write a register once the block has drained.
    task automatic write_reg(input t_cfg_idx idx, input logic [12:0] data);
        push <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        load_reg(idx, data);
        settings_run++;
    endtask

    // Send one bitmap body for the current setting, sometimes cut short by end of stream.
    task automatic feed_image();
        int unsigned words;
        int unsigned cut;
        int unsigned ndig;
        logic [3:0]  nib;
        logic [7:0]  ch;
        words = words_left;
        cut   = words;
        if (words > 40) cut = $urandom_range(3);
        else if ($urandom_range(99) < 15) cut = $urandom_range(words - 1);
        for (int unsigned w = 0; w < cut && !image_done; w++) begin
            if ($urandom_range(99) < 8) feed_char(8'($urandom_range(255)), 1'b0);
            if ($urandom_range(99) < 90) begin
                feed_char(8'h30, 1'b0);
                feed_char($urandom_range(1) ? 8'h78 : 8'h58, 1'b0);
            end
            ndig = reg_short ? 4 : 2;
            if ($urandom_range(99) < 15) ndig = $urandom_range(1, 6);
            repeat (ndig) begin
                nib = 4'($urandom_range(15));
                if (nib < 10) ch = 8'h30 + nib;
                else if ($urandom_range(1)) ch = 8'h37 + nib;
                else ch = 8'h57 + nib;
                feed_char(ch, 1'b0);
            end
            case ($urandom_range(4))
                0:       ch = CH_SPACE;
                1:       ch = CH_COMMA;
                2:       ch = CH_RBRACE;
                3:       ch = CH_LF;
                default: ch = CH_TAB;
            endcase
            feed_char(ch, 1'b0);
            if ($urandom_range(99) < 40) feed_char($urandom_range(1) ? CH_SPACE : CH_LF, 1'b0);
        end
        if (!image_done) feed_char(8'($urandom_range(255)), 1'b1);
        // Trailing text after the image is dropped.
        feed_char(8'($urandom_range(255)), 1'b0);
        feed_char(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [12:0] pick_dim();
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(4))
                0:       return 13'd0;
                1:       return 13'd1;
                2:       return 13'd4096;
                3:       return 13'd4097;
                default: return 13'h1FFF;
            endcase
        end
        return 13'($urandom_range(1, 3));
    endfunction

    always @(posedge i_clk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            pop <= 1'b0;
            hold_count++;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) quiet_cycles = 0;
        else quiet_cycles++;
        if (i_rst_n && pop && !empty) begin
            if (pixels_due.size() == 0) begin
                $error("result with nothing expected: %h", o_result);
                mismatches++;
            end else begin
                want = pixels_due.pop_front();
                if (want.load_error) errors_seen++;
                else pixels_seen++;
                if (o_result.pixel_color !== want.pixel_color) begin
                    $error("pixel_color: expected %h, got %h",
                           want.pixel_color, o_result.pixel_color);
                    mismatches++;
                end
                if (o_result.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, o_result.last_of_run);
                    mismatches++;
                end
                if (o_result.image_complete !== want.image_complete) begin
                    $error("image_complete: expected %b, got %b",
                           want.image_complete, o_result.image_complete);
                    mismatches++;
                end
                if (o_result.load_error !== want.load_error) begin
                    $error("load_error: expected %b, got %b",
                           want.load_error, o_result.load_error);
                    mismatches++;
                end
            end
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [12:0] w_val;
        logic [12:0] h_val;
        logic [12:0] m_val;
        int          phase;
        reg_width  = 13'd1;
        reg_height = 13'd1;
        reg_short  = 1'b0;
        restart_decode();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_REG) write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            else offer(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);
        end

        phase = 0;
        while (chars_fed < CHAR_TARGET) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (phase == 0) begin
                // Pressure: enough words to back the block up during the hold-off.
                w_val = 13'd16;
                h_val = 13'd8;
                m_val = 13'd0;
            end else begin
                w_val = ($urandom_range(99) < 80) ? 13'($urandom_range(1, 24)) : pick_dim();
                if (w_val == 13'd3) w_val = 13'($urandom_range(25, 70));
                h_val = pick_dim();
                m_val = 13'($urandom_range(8191));
            end
            write_reg(CFG_IDX_WIDTH, w_val);
            write_reg(CFG_IDX_HEIGHT, h_val);
            write_reg(CFG_IDX_MODE, m_val);
            if (phase == 0) long_hold = 1'b1;
            feed_image();
            phase++;
        end

        push <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("Fed %0d body characters across %0d register writes and %0d images;",
                 chars_fed, settings_run, phase);
        $display("checked %0d pixels and %0d early-end errors.", pixels_seen, errors_seen);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/xbm_pkg.sv
hdl/xbm_fifo.sv
hdl/xbm_cfg.sv
hdl/xbm_front.sv
hdl/xbm_back.sv
hdl/xbm_hex_to_pixel_decoder.sv
tb/xbm_hex_to_pixel_decoder_test.sv
